FILE: src/quaternion_product_and_rotate_core_macros.svh
// assertion macros shared by the quaternion core rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef QUATERNION_PRODUCT_AND_ROTATE_CORE_MACROS_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define QPR_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define QPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/qpr_pkg.sv
// shared types and constants for the quaternion product and rotate core
// no dependencies
`timescale 1ns / 1ps

package qpr_pkg;

	// operation selected by the kind field
	typedef enum logic {
		KIND_PRODUCT = 1'b0,
		KIND_ROTATE  = 1'b1
	} kind_t;

	// component positions in operand and result arrays
	localparam int unsigned IDX_X    = 0;
	localparam int unsigned IDX_Y    = 1;
	localparam int unsigned IDX_Z    = 2;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned NUM_COMP = 4;

	// integer bits of a component, the rest are fraction bits
	localparam int unsigned INT_BITS = 2;

	// per-component saturation flags of one product
	typedef struct packed {
		logic x;
		logic y;
		logic z;
		logic w;
	} sat_t;

endpackage

FILE: src/qpr_qmul.sv
// two-stage pipelined quaternion product: 16 multipliers, then sum, round, saturate
// depends on qpr_pkg and the core assertion macros
`timescale 1ns / 1ps
`include "quaternion_product_and_rotate_core_macros.svh"

module qpr_qmul #(
	parameter int unsigned W   = 16,
	parameter int unsigned SBW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [W:0]    lhs [qpr_pkg::NUM_COMP],
	input  logic signed [W:0]    rhs [qpr_pkg::NUM_COMP],
	input  logic [SBW-1:0]       side_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [W-1:0]  res [qpr_pkg::NUM_COMP],
	output qpr_pkg::sat_t        sat,
	output logic [SBW-1:0]       side_out
);
	import qpr_pkg::*;

	localparam int unsigned PW = 2 * W + 2;
	localparam int unsigned SW = PW + 2;
	localparam int unsigned F  = W - INT_BITS;
	localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (F - 1));
	localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] MINV = ~MAXV;
	localparam logic signed [W-1:0]  MAX_OUT = MAXV[W-1:0];
	localparam logic signed [W-1:0]  MIN_OUT = MINV[W-1:0];

	// terms subtracted in each component sum, bit k of row c
	localparam logic [NUM_COMP-1:0] NEG_MASK [NUM_COMP] = '{
		4'b1000, 4'b1000, 4'b1000, 4'b1110
	};

	logic                  vld_s1, vld_s2;
	logic                  ready_s1, ready_s2;
	logic signed [PW-1:0]  prod_d  [NUM_COMP][NUM_COMP];
	logic signed [PW-1:0]  prod_s1 [NUM_COMP][NUM_COMP];
	logic [SBW-1:0]        side_s1, side_s2;
	logic signed [W-1:0]   res_d   [NUM_COMP];
	logic signed [W-1:0]   res_s2  [NUM_COMP];
	logic [NUM_COMP-1:0]   sat_vec;
	sat_t                  sat_s2;

	assign ready_s2 = !vld_s2 || out_ready;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign in_ready = ready_s1;

	// x = lw*rx + rw*lx + ry*lz - rz*ly
	assign prod_d[IDX_X][0] = lhs[IDX_W] * rhs[IDX_X];
	assign prod_d[IDX_X][1] = rhs[IDX_W] * lhs[IDX_X];
	assign prod_d[IDX_X][2] = rhs[IDX_Y] * lhs[IDX_Z];
	assign prod_d[IDX_X][3] = rhs[IDX_Z] * lhs[IDX_Y];
	// y = lw*ry + rw*ly + rz*lx - rx*lz
	assign prod_d[IDX_Y][0] = lhs[IDX_W] * rhs[IDX_Y];
	assign prod_d[IDX_Y][1] = rhs[IDX_W] * lhs[IDX_Y];
	assign prod_d[IDX_Y][2] = rhs[IDX_Z] * lhs[IDX_X];
	assign prod_d[IDX_Y][3] = rhs[IDX_X] * lhs[IDX_Z];
	// z = lw*rz + rw*lz + rx*ly - ry*lx
	assign prod_d[IDX_Z][0] = lhs[IDX_W] * rhs[IDX_Z];
	assign prod_d[IDX_Z][1] = rhs[IDX_W] * lhs[IDX_Z];
	assign prod_d[IDX_Z][2] = rhs[IDX_X] * lhs[IDX_Y];
	assign prod_d[IDX_Z][3] = rhs[IDX_Y] * lhs[IDX_X];
	// w = lw*rw - dot
	assign prod_d[IDX_W][0] = lhs[IDX_W] * rhs[IDX_W];
	assign prod_d[IDX_W][1] = rhs[IDX_X] * lhs[IDX_X];
	assign prod_d[IDX_W][2] = rhs[IDX_Y] * lhs[IDX_Y];
	assign prod_d[IDX_W][3] = rhs[IDX_Z] * lhs[IDX_Z];

	// exact sum, round half up, saturate
	always_comb begin
		logic signed [SW-1:0] acc;
		logic signed [SW-1:0] rnd;
		for (int c = 0; c < NUM_COMP; c++) begin
			acc = '0;
			for (int k = 0; k < NUM_COMP; k++) begin
				if (NEG_MASK[c][k]) begin
					acc = acc - SW'(prod_s1[c][k]);
				end else begin
					acc = acc + SW'(prod_s1[c][k]);
				end
			end
			rnd = (acc + HALF) >>> F;
			if (rnd > MAXV) begin
				res_d[c]   = MAX_OUT;
				sat_vec[c] = 1'b1;
			end else if (rnd < MINV) begin
				res_d[c]   = MIN_OUT;
				sat_vec[c] = 1'b1;
			end else begin
				res_d[c]   = rnd[W-1:0];
				sat_vec[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				vld_s1 <= in_valid;
			end
			if (ready_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			prod_s1 <= prod_d;
			side_s1 <= side_in;
		end
		if (vld_s1 && ready_s2) begin
			res_s2 <= res_d;
			sat_s2 <= '{x: sat_vec[IDX_X], y: sat_vec[IDX_Y],
				z: sat_vec[IDX_Z], w: sat_vec[IDX_W]};
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign res       = res_s2;
	assign sat       = sat_s2;
	assign side_out  = side_s2;

	`QPR_ASSERT_NEXT(a_qmul_hold_s1, vld_s1 && !ready_s2, vld_s1, "product stage lost an item")
	`QPR_ASSERT_IMPLIES(a_qmul_full_when_blocked, !in_ready, vld_s1 && vld_s2 && !out_ready, "blocked with a bubble")
	`QPR_ASSERT_IMPLIES(a_qmul_sat_x_limit, out_valid && sat.x, res[IDX_X] == MAX_OUT || res[IDX_X] == MIN_OUT, "saturated x not at a limit")

endmodule

FILE: src/quaternion_product_and_rotate_core.sv
// top level of the fixed-point quaternion product and vector rotation unit
// depends on qpr_pkg, qpr_qmul and the core assertion macros
//
// usage:
//  - input channel in_valid/in_ready carries one item: kind, left_x..left_w and
//    right_x..right_w, all components signed with two integer bits
//  - kind product gives left * right; kind rotate gives (conj(right) * v) * right
//    where v is left_x/y/z, and out_w reads zero
//  - output channel out_valid/out_ready carries out_x..out_w and overflow, set if any
//    rounded component of the first product, or for rotate x/y/z of the second, saturated
//  - pipeline: five register stages, the input register followed by the two product
//    units, with a result offered from the second product's result register
//  - throughput: one item per cycle while out_ready is high, set by the two fully
//    pipelined product units of sixteen multipliers each
//  - reset clears only the stage valid bits; the data registers are not reset
//  - a stalled receiver fills the pipeline stage by stage; in_ready drops only
//    once every stage holds an item
`timescale 1ns / 1ps
`include "quaternion_product_and_rotate_core_macros.svh"

module quaternion_product_and_rotate_core #(
	parameter int unsigned COMPONENT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic signed [COMPONENT_WIDTH-1:0] left_x,
	input  logic signed [COMPONENT_WIDTH-1:0] left_y,
	input  logic signed [COMPONENT_WIDTH-1:0] left_z,
	input  logic signed [COMPONENT_WIDTH-1:0] left_w,
	input  logic signed [COMPONENT_WIDTH-1:0] right_x,
	input  logic signed [COMPONENT_WIDTH-1:0] right_y,
	input  logic signed [COMPONENT_WIDTH-1:0] right_z,
	input  logic signed [COMPONENT_WIDTH-1:0] right_w,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COMPONENT_WIDTH-1:0] out_x,
	output logic signed [COMPONENT_WIDTH-1:0] out_y,
	output logic signed [COMPONENT_WIDTH-1:0] out_z,
	output logic signed [COMPONENT_WIDTH-1:0] out_w,
	output logic                              overflow
);
	import qpr_pkg::*;

	localparam int unsigned W  = COMPONENT_WIDTH;
	localparam int unsigned WP = W + 1;

	// sideband through the first product: kind and the right quaternion
	typedef struct packed {
		logic         kind;
		logic [W-1:0] w;
		logic [W-1:0] z;
		logic [W-1:0] y;
		logic [W-1:0] x;
	} side_a_t;

	// sideband through the second product: kind, first overflow, first result
	typedef struct packed {
		logic         kind;
		logic         ovf;
		logic [W-1:0] w;
		logic [W-1:0] z;
		logic [W-1:0] y;
		logic [W-1:0] x;
	} side_b_t;

	logic                 vld_s1;
	logic                 ready_s1;
	logic signed [WP-1:0] lhs_d  [NUM_COMP];
	logic signed [WP-1:0] rhs_d  [NUM_COMP];
	logic signed [WP-1:0] lhs_s1 [NUM_COMP];
	logic signed [WP-1:0] rhs_s1 [NUM_COMP];
	side_a_t              side_a_s1;

	logic                 a_in_ready, a_out_valid;
	logic signed [W-1:0]  res_a [NUM_COMP];
	sat_t                 sat_a;
	side_a_t              side_a_o;

	logic signed [WP-1:0] lhs_b [NUM_COMP];
	logic signed [WP-1:0] rhs_b [NUM_COMP];
	side_b_t              side_b_i, side_b_o;
	logic                 b_in_ready;
	logic signed [W-1:0]  res_b [NUM_COMP];
	sat_t                 sat_b;
	logic                 rotate_o;

	// operand select: rotation first forms conj(right) * (v, 0); negation kept one bit wider
	always_comb begin
		if (kind_t'(kind) == KIND_ROTATE) begin
			lhs_d[IDX_X] = -WP'(right_x);
			lhs_d[IDX_Y] = -WP'(right_y);
			lhs_d[IDX_Z] = -WP'(right_z);
			lhs_d[IDX_W] = WP'(right_w);
			rhs_d[IDX_X] = WP'(left_x);
			rhs_d[IDX_Y] = WP'(left_y);
			rhs_d[IDX_Z] = WP'(left_z);
			rhs_d[IDX_W] = '0;
		end else begin
			lhs_d[IDX_X] = WP'(left_x);
			lhs_d[IDX_Y] = WP'(left_y);
			lhs_d[IDX_Z] = WP'(left_z);
			lhs_d[IDX_W] = WP'(left_w);
			rhs_d[IDX_X] = WP'(right_x);
			rhs_d[IDX_Y] = WP'(right_y);
			rhs_d[IDX_Z] = WP'(right_z);
			rhs_d[IDX_W] = WP'(right_w);
		end
	end

	// input stage: ready whenever it is empty or the first product can take its item
	assign ready_s1 = !vld_s1 || a_in_ready;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			lhs_s1    <= lhs_d;
			rhs_s1    <= rhs_d;
			side_a_s1 <= '{kind: kind, w: right_w, z: right_z, y: right_y, x: right_x};
		end
	end

	// first product: the whole result for kind product, conj(right) * v for rotation
	qpr_qmul #(
		.W   (W),
		.SBW ($bits(side_a_t))
	) u_qmul_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (a_in_ready),
		.lhs       (lhs_s1),
		.rhs       (rhs_s1),
		.side_in   (side_a_s1),
		.out_valid (a_out_valid),
		.out_ready (b_in_ready),
		.res       (res_a),
		.sat       (sat_a),
		.side_out  (side_a_o)
	);

	// second product operands: rounded intermediate times the right quaternion
	always_comb begin
		for (int c = 0; c < NUM_COMP; c++) begin
			lhs_b[c] = WP'(res_a[c]);
		end
		rhs_b[IDX_X] = WP'($signed(side_a_o.x));
		rhs_b[IDX_Y] = WP'($signed(side_a_o.y));
		rhs_b[IDX_Z] = WP'($signed(side_a_o.z));
		rhs_b[IDX_W] = WP'($signed(side_a_o.w));
	end

	assign side_b_i = '{kind: side_a_o.kind, ovf: |sat_a,
		w: res_a[IDX_W], z: res_a[IDX_Z], y: res_a[IDX_Y], x: res_a[IDX_X]};

	// second product; its result register doubles as the output register
	qpr_qmul #(
		.W   (W),
		.SBW ($bits(side_b_t))
	) u_qmul_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_out_valid),
		.in_ready  (b_in_ready),
		.lhs       (lhs_b),
		.rhs       (rhs_b),
		.side_in   (side_b_i),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res_b),
		.sat       (sat_b),
		.side_out  (side_b_o)
	);

	// rotation takes the second product's vector, w of the final product is discarded
	assign rotate_o = kind_t'(side_b_o.kind) == KIND_ROTATE;

	always_comb begin
		if (rotate_o) begin
			out_x    = res_b[IDX_X];
			out_y    = res_b[IDX_Y];
			out_z    = res_b[IDX_Z];
			out_w    = '0;
			overflow = side_b_o.ovf | sat_b.x | sat_b.y | sat_b.z;
		end else begin
			out_x    = $signed(side_b_o.x);
			out_y    = $signed(side_b_o.y);
			out_z    = $signed(side_b_o.z);
			out_w    = $signed(side_b_o.w);
			overflow = side_b_o.ovf;
		end
	end

	`QPR_ASSERT_IMPLIES(a_rotate_w_zero, out_valid && rotate_o, out_w == '0, "rotation result w not zero")
	`QPR_ASSERT_IMPLIES(a_stall_from_output, !in_ready, out_valid && !out_ready, "input blocked without output stall")
	`QPR_ASSERT_NEXT(a_accept_loads_s1, in_valid && in_ready, vld_s1, "accepted item not held in input stage")

endmodule
